FILE: design/mft_pkg.sv
// Shared types and constants for the motor feedback turn tracker.
// No dependencies; every other file in the block imports this package.
package mft_pkg;

	// Motor group size and the width of a motor index
	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_IDX_W = 2;

	// Input command codes
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	// Result kind codes
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_IGNORED = 2'd1;
	localparam logic [1:0] KIND_CHECK   = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ID        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_TURN = 2'd2;
	localparam int CFG_DATA_W = 15;

	// Reset values of the configuration registers
	localparam logic [10:0] BASE_ID_RST         = 11'd513;
	localparam logic [14:0] WRAP_THRESHOLD_RST  = 15'd6500;
	localparam logic [14:0] COUNTS_PER_TURN_RST = 15'd8192;

	typedef struct packed {
		logic [10:0] base_id;
		logic [14:0] wrap_threshold;
		logic [14:0] counts_per_turn;
	} mft_cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [10:0] frame_id;
		logic [7:0]  angle_high;
		logic [7:0]  angle_low;
		logic [7:0]  speed_high;
		logic [7:0]  speed_low;
		logic [7:0]  current_high;
		logic [7:0]  current_low;
		logic [7:0]  temperature_byte;
	} mft_item_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [MOTOR_IDX_W-1:0]  motor_index;
		logic signed [15:0]      angle;
		logic signed [15:0]      speed;
		logic signed [15:0]      current;
		logic [7:0]              temperature;
		logic signed [15:0]      turns;
		logic [MOTOR_COUNT-1:0]  offline_mask;
	} mft_res_t;

endpackage

FILE: design/motor_feedback_turn_tracker.sv
// Top level of the motor feedback turn tracker.
// Depends on mft_pkg, mft_cfg, mft_track and mft_scale.
//
//  channel | signals                         | direction | accepted when
//  in      | in_valid, in_ready, fields      | to block  | in_valid & in_ready
//  out     | out_valid, out_ready, fields    | from block| out_valid & out_ready
//  cfg     | cfg_valid, cfg_ready, index/data| to block  | cfg_valid & cfg_ready
//
// One item per cycle sustained while out_ready stays high; an item is captured in the
// input register, and its result, turn tracking and total angle multiply included,
// is loaded into the output register, which raises out_valid, as the item leaves it.
// Motor state updates as an item leaves the input register, so the next item
// sees it at once. Reset clears valids, motor state and config to defaults.
// A stall on out_ready backs up into the input register; in_ready drops only
// when both registers are full and out_ready is low.
module motor_feedback_turn_tracker
	import mft_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [10:0]             frame_id,
	input  logic [7:0]              angle_high,
	input  logic [7:0]              angle_low,
	input  logic [7:0]              speed_high,
	input  logic [7:0]              speed_low,
	input  logic [7:0]              current_high,
	input  logic [7:0]              current_low,
	input  logic [7:0]              temperature_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic [MOTOR_IDX_W-1:0]  motor_index,
	output logic signed [15:0]      angle,
	output logic signed [15:0]      speed,
	output logic signed [15:0]      current,
	output logic [7:0]              temperature,
	output logic signed [15:0]      turns,
	output logic signed [30:0]      multi_turn_angle,
	output logic [MOTOR_COUNT-1:0]  offline_mask,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	mft_cfg_t  cfg;
	mft_item_t item_s1;
	logic      valid_s1;
	mft_res_t  res_comb;
	mft_res_t  res_q;
	logic      out_valid_q;

	logic ready_out;
	logic adv_s1;

	// Stage handshakes
	assign ready_out = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && ready_out;
	assign in_ready  = !valid_s1 || ready_out;

	mft_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Capture the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, frame_id: frame_id, angle_high: angle_high,
				angle_low: angle_low, speed_high: speed_high, speed_low: speed_low,
				current_high: current_high, current_low: current_low,
				temperature_byte: temperature_byte};
		end
	end

	mft_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.adv    (adv_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	mft_scale u_scale (
		.clk             (clk),
		.load            (adv_s1),
		.res_d           (res_comb),
		.counts_per_turn (cfg.counts_per_turn),
		.res_q           (res_q),
		.total_q         (multi_turn_angle)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign motor_index  = res_q.motor_index;
	assign angle        = res_q.angle;
	assign speed        = res_q.speed;
	assign current      = res_q.current;
	assign temperature  = res_q.temperature;
	assign turns        = res_q.turns;
	assign offline_mask = res_q.offline_mask;

endmodule

FILE: design/mft_cfg.sv
// Configuration registers of the turn tracker.
// Depends on mft_pkg for the register indexes, reset values and config struct.
module mft_cfg
	import mft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mft_cfg_t              cfg
);

	mft_cfg_t cfg_q;

	// Always take writes; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_id         <= BASE_ID_RST;
			cfg_q.wrap_threshold  <= WRAP_THRESHOLD_RST;
			cfg_q.counts_per_turn <= COUNTS_PER_TURN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE_ID:         cfg_q.base_id         <= cfg_data[10:0];
				REG_WRAP_THRESHOLD:  cfg_q.wrap_threshold  <= cfg_data[14:0];
				REG_COUNTS_PER_TURN: cfg_q.counts_per_turn <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: design/mft_track.sv
// Per-motor state and turn tracking for one item per cycle while adv is high.
// Depends on mft_pkg for the item, result and config structs.
module mft_track
	import mft_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mft_item_t item,
	input  logic      adv,
	input  mft_cfg_t  cfg,
	output mft_res_t  res
);

	logic signed [15:0]     last_q [MOTOR_COUNT];
	logic signed [15:0]     turn_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] seen_q;

	logic [11:0]             id_off;
	logic                    hit;
	logic [MOTOR_IDX_W-1:0]  idx;
	logic signed [15:0]      ang;
	logic signed [15:0]      old_turns;
	logic signed [16:0]      diff;
	logic signed [16:0]      thr;
	logic signed [15:0]      new_turns;

	// Select the motor from the identifier
	assign id_off = {1'b0, item.frame_id} - {1'b0, cfg.base_id};
	assign hit    = !id_off[11] && (id_off[10:0] < 11'(MOTOR_COUNT));
	assign idx    = id_off[MOTOR_IDX_W-1:0];

	// Detect a wrap against the last angle and step the turn count
	assign ang       = {item.angle_high, item.angle_low};
	assign old_turns = turn_q[idx];
	assign diff      = 17'(ang) - 17'(last_q[idx]);
	assign thr       = {2'b00, cfg.wrap_threshold};

	always_comb begin
		new_turns = old_turns;
		priority if (diff < -thr) begin
			if (old_turns != 16'sh7fff) new_turns = old_turns + 16'sd1;
		end else if (diff > thr) begin
			if (old_turns != -16'sh8000) new_turns = old_turns - 16'sd1;
		end
	end

	// Build the result for the item in the input register
	always_comb begin
		res = '0;
		priority if (item.cmd == CMD_CHECK) begin
			res.kind         = KIND_CHECK;
			res.offline_mask = ~seen_q;
		end else if (!hit) begin
			res.kind = KIND_IGNORED;
		end else begin
			res.kind        = KIND_FRAME;
			res.motor_index = idx;
			res.angle       = ang;
			res.speed       = {item.speed_high, item.speed_low};
			res.current     = {item.current_high, item.current_low};
			res.temperature = item.temperature_byte;
			res.turns       = new_turns;
		end
	end

	// Update motor state as the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_q[i] <= '0;
				turn_q[i] <= '0;
			end
		end else if (adv) begin
			if (item.cmd == CMD_CHECK) begin
				seen_q <= '0;
			end else if (hit) begin
				seen_q[idx] <= 1'b1;
				last_q[idx] <= ang;
				turn_q[idx] <= new_turns;
			end
		end
	end

`ifndef SYNTHESIS
	a_check_clears_seen: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.cmd == CMD_CHECK |=> seen_q == '0)
		else $error("seen marks not cleared after check");
	a_frame_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.cmd == CMD_FRAME && hit |=> seen_q[$past(idx)])
		else $error("decoded frame did not mark its motor");
	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.kind == KIND_FRAME |-> (new_turns == old_turns)
		|| (new_turns == old_turns + 16'sd1) || (new_turns == old_turns - 16'sd1))
		else $error("turn count moved by more than one");
`endif

endmodule

FILE: design/mft_scale.sv
// Output register stage: forms the unwrapped total angle.
// Depends on mft_pkg for the result struct.
module mft_scale
	import mft_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  mft_res_t           res_d,
	input  logic [14:0]        counts_per_turn,
	output mft_res_t           res_q,
	output logic signed [30:0] total_q
);

	logic signed [31:0] product;
	logic signed [31:0] total;

	// Multiply turns by counts per turn and add the angle; range fits 31 bits
	assign product = 32'(res_d.turns) * 32'(signed'({1'b0, counts_per_turn}));
	assign total   = product + 32'(res_d.angle);

	// Hold the result until the consumer takes it
	always_ff @(posedge clk) begin
		if (load) begin
			res_q   <= res_d;
			total_q <= total[30:0];
		end
	end

endmodule
